[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// shared types, character classes and token code tables for the tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

  // input beat: one source byte or the end-of-input mark
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  // output beat: one result of a token run
  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] text_char;
    logic       has_char;
    logic       token_end;
    logic [2:0] error_code;
    logic       run_last;
  } out_item_t;

  // one result beat as issued by the scanner before the text byte is read
  typedef struct packed {
    logic [4:0] kind;
    logic       use_ram;
    logic       tok_end;
    logic [2:0] err;
    logic       last;
  } beat_t;

  // token kinds
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_STRING  = 5'd2;
  localparam logic [4:0] KIND_SYMBOL  = 5'd3;
  localparam logic [4:0] KIND_KW_BASE = 5'd4;
  localparam logic [4:0] KIND_OP_BASE = 5'd9;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_LETTER     = 3'd1;
  localparam logic [2:0] ERR_EXTRA_DOT  = 3'd2;
  localparam logic [2:0] ERR_TRAIL_DOT  = 3'd3;
  localparam logic [2:0] ERR_UNTERM_STR = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd5;

  // scan modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_SYMBOL = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_ESCAPE = 3'd4;

  // special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // keywords: string, integer, if, for, while
  localparam int KW_NUM    = 5;
  localparam int KW_MAXLEN = 8;

  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd6, 3'd7, 3'd2, 3'd3, 3'd5};

  localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAXLEN] = '{
    '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67, 8'h00, 8'h00},  // string
    '{8'h69, 8'h6E, 8'h74, 8'h65, 8'h67, 8'h65, 8'h72, 8'h00},  // integer
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // for
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00}   // while
  };

  // single-character operators in token-kind order
  localparam int OP_NUM = 18;

  localparam logic [7:0] OP_CHARS [OP_NUM] = '{
    8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28,
    8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h2E, 8'h2C, 8'h3A, 8'h3B
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // operator kind of a byte, KIND_END when it is no operator
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] r;
    r = KIND_END;
    for (int k = 0; k < OP_NUM; k++) begin
      if (c == OP_CHARS[k]) begin
        r = KIND_OP_BASE + 5'(k);
      end
    end
    return r;
  endfunction

endpackage

[rtl/stt_out_fifo.sv]
// ----------------------------------------------------------------------------
// stt_out_fifo
// two-entry result queue between the scanner and the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stt_pkg::out_item_t push_item,
  output logic [1:0]        level,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output stt_pkg::out_item_t out_data
);
  import stt_pkg::*;

  out_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid & out_ready;
  assign level     = count;
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/stt_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// stt_scan_ctrl
// scan state, text buffer memory and the sequencer that plays out token runs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_scan_ctrl #(
  parameter int MAX_TEXT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stt_pkg::in_item_t  in_data,
  input  logic [1:0]         fifo_level,
  input  logic               fifo_pop,
  output logic               push,
  output stt_pkg::out_item_t push_item
);
  import stt_pkg::*;

  localparam int LW = $clog2(MAX_TEXT + 1);
  localparam int AW = $clog2(MAX_TEXT);

  localparam logic [2:0] ST_WAIT   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_SINGLE = 3'd2;
  localparam logic [2:0] ST_TAIL   = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  localparam logic [1:0] CLOSE_NONE   = 2'd0;
  localparam logic [1:0] CLOSE_SINGLE = 2'd1;
  localparam logic [1:0] CLOSE_SWEEP  = 2'd2;

  // control registers
  logic [2:0]        state, state_next;
  logic [2:0]        mode;
  logic [LW-1:0]     text_len;
  logic [1:0]        dot_cnt;
  logic              dot_end;
  logic [KW_NUM-1:0] kw_match;
  logic              tail_on;
  logic              wr_defer;
  logic [LW-1:0]     sweep_idx, sweep_idx_next;
  logic              pend_valid;

  // job payload registers
  logic [4:0]    close_kind;
  logic [2:0]    close_err;
  logic [4:0]    tail_kind;
  logic [LW-1:0] sweep_len;
  logic [7:0]    defer_data;
  beat_t         pend_beat;

  // text memory
  logic [7:0]    text_mem [MAX_TEXT];
  logic [7:0]    rd_data;
  logic          ram_rd;
  logic [AW-1:0] ram_rd_addr;
  logic          ram_wr;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;

  // input decode
  logic       acc;
  logic [7:0] c;
  logic       eoi;
  logic       c_dig, c_let, c_spc, c_quo, c_bsl, c_dot, c_nul;
  logic [4:0] c_op;
  logic       app_ovf;

  // start-from-idle outcome of the current byte
  logic [2:0]        sid_mode;
  logic [LW-1:0]     sid_len;
  logic [KW_NUM-1:0] sid_kwm;
  logic              sid_wr;
  logic              sid_tail;
  logic [4:0]        sid_tail_kind;

  // keyword tracking and token close results
  logic [KW_NUM-1:0] kw_next;
  logic              kw_hit;
  logic [4:0]        kw_kind;
  logic [1:0]        num_close;
  logic [2:0]        num_err;
  logic [1:0]        sym_close;
  logic [4:0]        sym_kind;

  // decision on an accepted beat
  logic [1:0]        d_close;
  logic [4:0]        d_close_kind;
  logic [2:0]        d_close_err;
  logic              d_tail;
  logic [4:0]        d_tail_kind;
  logic [2:0]        d_mode;
  logic [LW-1:0]     d_len;
  logic [1:0]        d_dots;
  logic              d_dend;
  logic [KW_NUM-1:0] d_kwm;
  logic              d_wr;

  // beat issue
  logic [2:0] occ;
  logic       can_issue;
  logic       issue;
  beat_t      beat;
  logic       sweep_end;

  assign in_ready = (state == ST_WAIT);
  assign acc      = in_valid & in_ready;
  assign c        = in_data.char_code;
  assign eoi      = in_data.end_of_input;

  assign c_dig   = is_digit(c);
  assign c_let   = is_letter(c);
  assign c_spc   = is_space(c);
  assign c_quo   = (c == CH_QUOTE);
  assign c_bsl   = (c == CH_BSLASH);
  assign c_dot   = (c == CH_DOT);
  assign c_nul   = (c == CH_NUL);
  assign c_op    = op_kind(c);
  assign app_ovf = (text_len >= LW'(MAX_TEXT));

  // keyword prefix tracking for the byte appended at text_len
  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      kw_next[k] = kw_match[k] && (text_len < LW'(KW_MAXLEN)) &&
                   (text_len[2:0] < KW_LEN[k]) && (c == KW_TEXT[k][text_len[2:0]]);
    end
  end

  // whole-word keyword check at symbol close
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = KIND_SYMBOL;
    for (int k = 0; k < KW_NUM; k++) begin
      if (kw_match[k] && (text_len == LW'(KW_LEN[k]))) begin
        kw_hit  = 1'b1;
        kw_kind = KIND_KW_BASE + 5'(k);
      end
    end
    sym_close = kw_hit ? CLOSE_SINGLE : CLOSE_SWEEP;
    sym_kind  = kw_kind;
  end

  // number close: extra dot outranks trailing dot
  always_comb begin
    if (dot_cnt == 2'd2) begin
      num_close = CLOSE_SINGLE;
      num_err   = ERR_EXTRA_DOT;
    end else if (dot_end) begin
      num_close = CLOSE_SINGLE;
      num_err   = ERR_TRAIL_DOT;
    end else begin
      num_close = CLOSE_SWEEP;
      num_err   = ERR_NONE;
    end
  end

  // what the byte does when scanned from idle
  always_comb begin
    sid_mode      = MODE_IDLE;
    sid_len       = '0;
    sid_kwm       = '1;
    sid_wr        = 1'b0;
    sid_tail      = 1'b0;
    sid_tail_kind = c_op;
    if (!c_spc) begin
      if (c_quo) begin
        sid_mode = MODE_STRING;
      end else if (c_dig) begin
        sid_mode = MODE_NUMBER;
        sid_len  = LW'(1);
        sid_wr   = 1'b1;
      end else if (c_let) begin
        sid_mode = MODE_SYMBOL;
        sid_len  = LW'(1);
        sid_wr   = 1'b1;
        for (int k = 0; k < KW_NUM; k++) begin
          sid_kwm[k] = (c == KW_TEXT[k][0]);
        end
      end else if (c_op != KIND_END) begin
        sid_tail = 1'b1;
      end
    end
  end

  // per-beat decision
  always_comb begin
    d_close      = CLOSE_NONE;
    d_close_kind = KIND_END;
    d_close_err  = ERR_NONE;
    d_tail       = 1'b0;
    d_tail_kind  = KIND_END;
    d_mode       = mode;
    d_len        = text_len;
    d_dots       = dot_cnt;
    d_dend       = dot_end;
    d_kwm        = kw_match;
    d_wr         = 1'b0;

    if (eoi) begin
      unique case (mode)
        MODE_NUMBER: begin
          d_close      = num_close;
          d_close_kind = (num_close == CLOSE_SWEEP) ? KIND_NUMBER : KIND_END;
          d_close_err  = num_err;
        end
        MODE_SYMBOL: begin
          d_close      = sym_close;
          d_close_kind = sym_kind;
        end
        MODE_STRING, MODE_ESCAPE: begin
          d_close     = CLOSE_SINGLE;
          d_close_err = ERR_UNTERM_STR;
        end
        default: begin
          d_close = CLOSE_NONE;
        end
      endcase
      d_mode      = MODE_IDLE;
      d_len       = '0;
      d_dots      = 2'd0;
      d_dend      = 1'b0;
      d_kwm       = '1;
      d_tail      = 1'b1;
      d_tail_kind = KIND_END;
    end else begin
      unique case (mode)
        MODE_NUMBER: begin
          if (c_dig || c_dot) begin
            if (app_ovf) begin
              d_close     = CLOSE_SINGLE;
              d_close_err = ERR_OVERFLOW;
              d_mode      = MODE_IDLE;
              d_len       = '0;
              d_dots      = 2'd0;
              d_dend      = 1'b0;
            end else begin
              d_wr   = 1'b1;
              d_len  = text_len + LW'(1);
              d_dend = c_dot;
              if (c_dot && (dot_cnt != 2'd2)) begin
                d_dots = dot_cnt + 2'd1;
              end
            end
          end else if (c_let) begin
            d_close     = CLOSE_SINGLE;
            d_close_err = ERR_LETTER;
            d_mode      = MODE_IDLE;
            d_len       = '0;
            d_dots      = 2'd0;
            d_dend      = 1'b0;
          end else begin
            d_close      = num_close;
            d_close_kind = (num_close == CLOSE_SWEEP) ? KIND_NUMBER : KIND_END;
            d_close_err  = num_err;
            d_mode       = sid_mode;
            d_len        = sid_len;
            d_dots       = 2'd0;
            d_dend       = 1'b0;
            d_kwm        = sid_kwm;
            d_wr         = sid_wr;
            d_tail       = sid_tail;
            d_tail_kind  = sid_tail_kind;
          end
        end
        MODE_SYMBOL: begin
          if (c_let || c_dig) begin
            if (app_ovf) begin
              d_close     = CLOSE_SINGLE;
              d_close_err = ERR_OVERFLOW;
              d_mode      = MODE_IDLE;
              d_len       = '0;
              d_kwm       = '1;
            end else begin
              d_wr  = 1'b1;
              d_len = text_len + LW'(1);
              d_kwm = kw_next;
            end
          end else begin
            d_close      = sym_close;
            d_close_kind = sym_kind;
            d_mode       = sid_mode;
            d_len        = sid_len;
            d_kwm        = sid_kwm;
            d_wr         = sid_wr;
            d_tail       = sid_tail;
            d_tail_kind  = sid_tail_kind;
          end
        end
        MODE_STRING: begin
          if (c_quo) begin
            d_close      = (text_len == '0) ? CLOSE_SINGLE : CLOSE_SWEEP;
            d_close_kind = KIND_STRING;
            d_mode       = MODE_IDLE;
            d_len        = '0;
          end else if (c_nul) begin
            d_close     = CLOSE_SINGLE;
            d_close_err = ERR_UNTERM_STR;
            d_mode      = MODE_IDLE;
            d_len       = '0;
          end else if (c_bsl) begin
            d_mode = MODE_ESCAPE;
          end else if (app_ovf) begin
            d_close     = CLOSE_SINGLE;
            d_close_err = ERR_OVERFLOW;
            d_mode      = MODE_IDLE;
            d_len       = '0;
          end else begin
            d_wr  = 1'b1;
            d_len = text_len + LW'(1);
          end
        end
        MODE_ESCAPE: begin
          if (c_nul) begin
            d_close     = CLOSE_SINGLE;
            d_close_err = ERR_UNTERM_STR;
            d_mode      = MODE_IDLE;
            d_len       = '0;
          end else if (app_ovf) begin
            d_close     = CLOSE_SINGLE;
            d_close_err = ERR_OVERFLOW;
            d_mode      = MODE_IDLE;
            d_len       = '0;
          end else begin
            d_wr   = 1'b1;
            d_len  = text_len + LW'(1);
            d_mode = MODE_STRING;
          end
        end
        default: begin
          d_mode      = sid_mode;
          d_len       = sid_len;
          d_dots      = 2'd0;
          d_dend      = 1'b0;
          d_kwm       = sid_kwm;
          d_wr        = sid_wr;
          d_tail      = sid_tail;
          d_tail_kind = sid_tail_kind;
        end
      endcase
    end
  end

  // room in the queue for a beat issued now, counting the one in flight
  assign occ       = {1'b0, fifo_level} + {2'b00, pend_valid} - {2'b00, fifo_pop};
  assign can_issue = (occ <= 3'd1);
  assign sweep_end = (sweep_idx == (sweep_len - LW'(1)));

  // sequencer
  always_comb begin
    state_next     = state;
    sweep_idx_next = sweep_idx;
    issue          = 1'b0;
    ram_rd         = 1'b0;
    ram_rd_addr    = sweep_idx[AW-1:0];
    beat.kind      = close_kind;
    beat.use_ram   = 1'b0;
    beat.tok_end   = 1'b1;
    beat.err       = ERR_NONE;
    beat.last      = 1'b0;

    unique case (state)
      ST_WAIT: begin
        if (acc) begin
          if (d_close == CLOSE_SWEEP) begin
            state_next     = ST_SWEEP;
            sweep_idx_next = '0;
          end else if (d_close == CLOSE_SINGLE) begin
            state_next = ST_SINGLE;
          end else if (d_tail) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_SWEEP: begin
        beat.use_ram = 1'b1;
        beat.tok_end = sweep_end;
        beat.last    = sweep_end && !tail_on;
        if (can_issue) begin
          issue          = 1'b1;
          ram_rd         = 1'b1;
          sweep_idx_next = sweep_idx + LW'(1);
          if (sweep_end) begin
            state_next = tail_on ? ST_TAIL : (wr_defer ? ST_FIN : ST_WAIT);
          end
        end
      end
      ST_SINGLE: begin
        beat.err  = close_err;
        beat.last = !tail_on;
        if (can_issue) begin
          issue      = 1'b1;
          state_next = tail_on ? ST_TAIL : (wr_defer ? ST_FIN : ST_WAIT);
        end
      end
      ST_TAIL: begin
        beat.kind = tail_kind;
        beat.last = 1'b1;
        if (can_issue) begin
          issue      = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_FIN: begin
        state_next = ST_WAIT;
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase
  end

  // a new token started after a close is written once the old text is read
  assign ram_wr      = (acc && d_wr && (d_close == CLOSE_NONE)) ||
                       ((state == ST_FIN) && wr_defer);
  assign ram_wr_addr = (state == ST_FIN) ? '0 : text_len[AW-1:0];
  assign ram_wr_data = (state == ST_FIN) ? defer_data : c;

  always_ff @(posedge clk) begin
    if (ram_rd) begin
      rd_data <= text_mem[ram_rd_addr];
    end
    if (ram_wr) begin
      text_mem[ram_wr_addr] <= ram_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WAIT;
      mode       <= MODE_IDLE;
      text_len   <= '0;
      dot_cnt    <= 2'd0;
      dot_end    <= 1'b0;
      kw_match   <= '1;
      tail_on    <= 1'b0;
      wr_defer   <= 1'b0;
      sweep_idx  <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_idx  <= sweep_idx_next;
      pend_valid <= issue;
      if (acc) begin
        mode     <= d_mode;
        text_len <= d_len;
        dot_cnt  <= d_dots;
        dot_end  <= d_dend;
        kw_match <= d_kwm;
        tail_on  <= d_tail;
        wr_defer <= d_wr && (d_close != CLOSE_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      close_kind <= d_close_kind;
      close_err  <= d_close_err;
      tail_kind  <= d_tail_kind;
      sweep_len  <= text_len;
      defer_data <= c;
    end
    if (issue) begin
      pend_beat <= beat;
    end
  end

  // second stage: text byte arrives from the memory read register
  assign push                 = pend_valid;
  assign push_item.token_kind = pend_beat.kind;
  assign push_item.text_char  = pend_beat.use_ram ? rd_data : 8'h00;
  assign push_item.has_char   = pend_beat.use_ram;
  assign push_item.token_end  = pend_beat.tok_end;
  assign push_item.error_code = pend_beat.err;
  assign push_item.run_last   = pend_beat.last;

endmodule

[rtl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer
// streaming lexical tokenizer: source bytes in, token result beats out
// ----------------------------------------------------------------------------
// usage
//   in channel: one beat per source byte, or a beat with end_of_input set
//   out channel: tokens leave as runs of beats, one per text character;
//     keywords, operators, errors and the end token are one beat each,
//     token_end marks the last beat of a token, run_last the last beat
//     caused by one input beat
//   result path: each result beat passes from the sequencer through the beat
//     register and the text memory read register into the result queue
//   flow: a byte that only extends a token issues no result beat and leaves
//     in_ready high; the result beats of a run issue one after another,
//     paced by the single read port of the text memory; a token close that
//     also starts a new number or symbol adds ST_FIN for the deferred write
//   reset: scanner returns to idle with an empty text buffer; the buffer
//     memory itself is not cleared, only entries already written are read
//   stall: result beats collect in a two-entry queue; when the receiver
//     stalls the sequencer holds, and no new byte is taken until the
//     current byte's results have all been issued
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_text_tokenizer #(
  parameter int MAX_TEXT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stt_pkg::out_item_t out_data
);
  import stt_pkg::*;

  // link between scanner and result queue
  logic       push;
  out_item_t  push_item;
  logic [1:0] fifo_level;
  logic       fifo_pop;

  // scanner: mode registers, text memory and token run sequencer
  stt_scan_ctrl #(
    .MAX_TEXT (MAX_TEXT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .fifo_level (fifo_level),
    .fifo_pop   (fifo_pop),
    .push       (push),
    .push_item  (push_item)
  );

  // result queue decouples the scanner from output backpressure
  stt_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .level     (fifo_level),
    .pop       (fifo_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for source_text_tokenizer: a short scripted byte stream
// (reset state, byte extremes, every error code but overflow) followed by random
// token streams; every result beat is compared field by field against a typed-in
// result or an in-bench tokenizer model, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import stt_pkg::*;

  localparam int TEXT_MAX     = 32;       // text buffer size of the dut
  localparam int RANDOM_BEATS = 170;      // random beats that do real work
  localparam int SCRIPT_LEN   = 28;
  localparam int SETTLE_CYCLES = 16;      // quiet cycles after the last result
  localparam bit TYPED = 1'b1;            // scripted row with a typed-in result
  localparam bit MODEL = 1'b0;            // scripted row checked by the model

  // one scripted input beat; kind and err only matter on typed rows, whose
  // single result is a one-beat token closing its run
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    logic [4:0] kind;
    logic [2:0] err;
  } script_row_t;

  // clock, reset and dut ports; the ones the bench drives are known from time zero
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // scanner state of the bench model
  logic [2:0] mode_q;
  logic [7:0] text_buf [TEXT_MAX];
  int         text_len;
  int         dot_seen;             // saturates at two
  bit         dot_last;

  out_item_t  step_res [$];         // results of the beat being predicted
  out_item_t  pending [$];          // results still owed by the dut
  in_item_t   plan [$];             // beats of the next random token

  string kw_words [5] = '{"string", "integer", "if", "for", "while"};
  string op_set    = "=!<>{}[]()+-/*.,:;";
  string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string sep_set   = " \t\n;,()=+-*/<>!{}[]:";

  // run statistics
  int  mismatches    = 0;
  int  beats_sent    = 0;
  int  useful_beats  = 0;
  int  results_seen  = 0;
  int  tokens_seen   = 0;
  int  errors_seen   = 0;
  int  overflows     = 0;
  bit  tx_calm       = 1'b0;
  bit  rx_calm       = 1'b0;
  int  rx_hold       = 0;

  // scripted opening: reset state, byte extremes, each error code but overflow,
  // keyword, empty string and end-of-input handling
  script_row_t script_rows [SCRIPT_LEN] = '{
    '{"=",   1'b0, TYPED, KIND_OP_BASE,          ERR_NONE},        // op right after reset
    '{8'h00, 1'b0, MODEL, KIND_END,              ERR_NONE},        // nul in idle: ignored
    '{8'hFF, 1'b0, MODEL, KIND_END,              ERR_NONE},        // top byte: ignored
    '{"1",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"a",   1'b0, TYPED, KIND_END,              ERR_LETTER},      // letter after number
    '{"\"",  1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"\"",  1'b0, TYPED, KIND_STRING,           ERR_NONE},        // empty string
    '{"\"",  1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"\\",  1'b0, MODEL, KIND_END,              ERR_NONE},
    '{8'h00, 1'b0, TYPED, KIND_END,              ERR_UNTERM_STR},  // nul after backslash
    '{"i",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"f",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{" ",   1'b0, TYPED, KIND_KW_BASE + 5'd2,   ERR_NONE},        // keyword if
    '{"7",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{".",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{" ",   1'b0, TYPED, KIND_END,              ERR_TRAIL_DOT},   // trailing dot
    '{"4",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{".",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"5",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{".",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{";",   1'b0, MODEL, KIND_END,              ERR_NONE},        // extra dot beats trailing
    '{"_",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"9",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"}",   1'b0, MODEL, KIND_END,              ERR_NONE},        // symbol closed by op
    '{"\"",  1'b0, MODEL, KIND_END,              ERR_NONE},
    '{"q",   1'b0, MODEL, KIND_END,              ERR_NONE},
    '{8'hFF, 1'b1, MODEL, KIND_END,              ERR_NONE},        // end inside a string
    '{8'h00, 1'b1, TYPED, KIND_END,              ERR_NONE}         // bare end token
  };

  source_text_tokenizer #(.MAX_TEXT(TEXT_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // tokenizer model
  // --------------------------------------------------------------------------

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic bit blank_ch(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void put_res(input logic [4:0] kind, input logic [7:0] ch,
                                  input logic has, input logic tok_last,
                                  input logic [2:0] err);
    out_item_t r;
    r = '{token_kind: kind, text_char: ch, has_char: has, token_end: tok_last,
          error_code: err, run_last: 1'b0};
    step_res.push_back(r);
  endfunction

  function automatic void clear_scan();
    mode_q   = MODE_IDLE;
    text_len = 0;
    dot_seen = 0;
    dot_last = 1'b0;
  endfunction

  // an error is a one-beat token of kind end
  function automatic void token_error(input logic [2:0] code);
    put_res(KIND_END, 8'h00, 1'b0, 1'b1, code);
    clear_scan();
  endfunction

  function automatic void flush_text(input logic [4:0] kind);
    if (text_len == 0) begin
      put_res(kind, 8'h00, 1'b0, 1'b1, ERR_NONE);
    end else begin
      for (int i = 0; i < text_len; i++)
        put_res(kind, text_buf[i], 1'b1, i + 1 == text_len, ERR_NONE);
    end
  endfunction

  // returns 0 when the byte does not fit and the overflow error went out
  function automatic bit store_char(input logic [7:0] c);
    if (text_len >= TEXT_MAX) begin
      token_error(ERR_OVERFLOW);
      return 1'b0;
    end
    text_buf[text_len] = c;
    text_len++;
    return 1'b1;
  endfunction

  function automatic void close_word();
    bit hit;
    for (int k = 0; k < 5; k++) begin
      if (text_len == kw_words[k].len()) begin
        hit = 1'b1;
        for (int i = 0; i < text_len; i++)
          if (text_buf[i] != kw_words[k][i]) hit = 1'b0;
        if (hit) begin
          put_res(KIND_KW_BASE + 5'(k), 8'h00, 1'b0, 1'b1, ERR_NONE);
          clear_scan();
          return;
        end
      end
    end
    flush_text(KIND_SYMBOL);
    clear_scan();
  endfunction

  // extra dot outranks trailing dot
  function automatic void close_number();
    if (dot_seen >= 2) begin
      token_error(ERR_EXTRA_DOT);
    end else if (dot_last) begin
      token_error(ERR_TRAIL_DOT);
    end else begin
      flush_text(KIND_NUMBER);
      clear_scan();
    end
  endfunction

  function automatic void start_from_idle(input logic [7:0] c);
    if (blank_ch(c)) return;
    if (c == CH_QUOTE) begin
      clear_scan();
      mode_q = MODE_STRING;
    end else if (digit_ch(c)) begin
      clear_scan();
      mode_q = MODE_NUMBER;
      void'(store_char(c));
    end else if (word_ch(c)) begin
      clear_scan();
      mode_q = MODE_SYMBOL;
      void'(store_char(c));
    end else begin
      for (int k = 0; k < op_set.len(); k++)
        if (op_set[k] == c) put_res(KIND_OP_BASE + 5'(k), 8'h00, 1'b0, 1'b1, ERR_NONE);
    end
  endfunction

  // works out every result one input beat causes, into step_res
  function automatic void scan_beat(input in_item_t beat);
    logic [7:0] c;
    out_item_t  tail;
    c = beat.char_code;
    step_res.delete();
    if (beat.end_of_input) begin
      case (mode_q)
        MODE_NUMBER: close_number();
        MODE_SYMBOL: close_word();
        MODE_STRING, MODE_ESCAPE: token_error(ERR_UNTERM_STR);
        default: ;
      endcase
      clear_scan();
      put_res(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
    end else begin
      case (mode_q)
        MODE_NUMBER: begin
          if (digit_ch(c) || c == CH_DOT) begin
            if (store_char(c)) begin
              if (c == CH_DOT && dot_seen < 2) dot_seen++;
              dot_last = (c == CH_DOT);
            end
          end else if (word_ch(c)) begin
            token_error(ERR_LETTER);
          end else begin
            close_number();
            start_from_idle(c);
          end
        end
        MODE_SYMBOL: begin
          if (word_ch(c) || digit_ch(c)) begin
            void'(store_char(c));
          end else begin
            close_word();
            start_from_idle(c);
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            flush_text(KIND_STRING);
            clear_scan();
          end else if (c == CH_NUL) begin
            token_error(ERR_UNTERM_STR);
          end else if (c == CH_BSLASH) begin
            mode_q = MODE_ESCAPE;
          end else begin
            void'(store_char(c));
          end
        end
        MODE_ESCAPE: begin
          if (c == CH_NUL) token_error(ERR_UNTERM_STR);
          else if (store_char(c)) mode_q = MODE_STRING;
        end
        default: begin
          mode_q = MODE_IDLE;
          start_from_idle(c);
        end
      endcase
    end
    if (step_res.size() > 0) begin
      tail = step_res.pop_back();
      tail.run_last = 1'b1;
      step_res.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // random token plans
  // --------------------------------------------------------------------------

  function automatic void add_char(input logic [7:0] c);
    in_item_t b;
    b.char_code    = c;
    b.end_of_input = 1'b0;
    plan.push_back(b);
  endfunction

  function automatic void add_eoi();
    in_item_t b;
    b.char_code    = 8'($urandom);   // payload byte is don't-care here
    b.end_of_input = 1'b1;
    plan.push_back(b);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    return alpha_set[$urandom_range(0, alpha_set.len() - 1)];
  endfunction

  // most plans are well-formed tokens with random content; one in a dozen numbers or
  // symbols runs long enough to overflow the text buffer
  function automatic void plan_token();
    int    pick;
    int    n;
    string w;
    logic [7:0] c;
    plan.delete();
    pick = $urandom_range(0, 19);
    if (pick <= 4) begin
      // number, sometimes with extra or trailing dots or a letter glued on
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 6);
      add_char(rand_digit());
      for (int i = 1; i < n; i++)
        add_char(($urandom_range(0, 5) == 0) ? CH_DOT : rand_digit());
      if ($urandom_range(0, 5) == 0) add_char(CH_DOT);
      if ($urandom_range(0, 4) == 0) add_char(rand_letter());
    end else if (pick <= 8) begin
      if ($urandom_range(0, 2) == 0) begin
        // keyword, exact or one letter off
        w = kw_words[$urandom_range(0, 4)];
        n = $urandom_range(0, 5);
        for (int i = 0; i < w.len() - (n == 0 ? 1 : 0); i++) add_char(w[i]);
        if (n == 1) add_char(rand_letter());
      end else begin
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 7);
        add_char(rand_letter());
        for (int i = 1; i < n; i++)
          add_char(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
      end
    end else if (pick <= 11) begin
      // quoted string with escapes, now and then unterminated or cut by a nul
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 6);
      add_char(CH_QUOTE);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(1, 255));
        if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 7) == 0) begin
          add_char(CH_BSLASH);
          if ($urandom_range(0, 24) == 0) c = CH_NUL;
        end
        add_char(c);
      end
      case ($urandom_range(0, 15))
        0, 1:    add_eoi();
        2:       add_char(CH_NUL);
        default: add_char(CH_QUOTE);
      endcase
    end else if (pick <= 14) begin
      add_char(op_set[$urandom_range(0, op_set.len() - 1)]);
    end else if (pick <= 16) begin
      add_char(($urandom_range(0, 1) == 0) ? " " : 8'($urandom_range(9, 13)));
    end else if (pick == 17) begin
      add_char(8'($urandom_range(0, 255)));
    end else if (pick == 18) begin
      add_eoi();
    end else begin
      add_char(8'($urandom_range(128, 255)));
    end
    // numbers and symbols get a separator half the time so they close cleanly
    if (pick <= 8 && $urandom_range(0, 1) == 0)
      add_char(sep_set[$urandom_range(0, sep_set.len() - 1)]);
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // one input beat: random gap, predict, hold valid until taken
  task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t typed_res);
    int         gap;
    logic [2:0] mode_was;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode_was = mode_q;
    scan_beat(beat);
    if (typed) pending.push_back(typed_res);
    else foreach (step_res[i]) pending.push_back(step_res[i]);
    // whitespace and unknown bytes in idle do not count as real work
    if (step_res.size() > 0 || mode_was != MODE_IDLE || mode_q != MODE_IDLE)
      useful_beats++;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // drop valid and hold off until the dut has delivered everything owed
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------

  function automatic void field_miss(input string fld, input logic [7:0] want,
                                     input logic [7:0] got);
    $display("%0t: %s expected %0d actual %0d", $time, fld, want, got);
    mismatches++;
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (got.token_end === 1'b1) tokens_seen++;
    if (got.error_code !== ERR_NONE) errors_seen++;
    if (got.error_code === ERR_OVERFLOW) overflows++;
    if (pending.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %p", $time, got);
      mismatches++;
      return;
    end
    want = pending[0];
    pending.delete(0);
    if (got.token_kind !== want.token_kind)
      field_miss("token_kind", 8'(want.token_kind), 8'(got.token_kind));
    if (got.text_char !== want.text_char)
      field_miss("text_char", want.text_char, got.text_char);
    if (got.has_char !== want.has_char)
      field_miss("has_char", 8'(want.has_char), 8'(got.has_char));
    if (got.token_end !== want.token_end)
      field_miss("token_end", 8'(want.token_end), 8'(got.token_end));
    if (got.error_code !== want.error_code)
      field_miss("error_code", 8'(want.error_code), 8'(got.error_code));
    if (got.run_last !== want.run_last)
      field_miss("run_last", 8'(want.run_last), 8'(got.run_last));
  endfunction

  // receiver: check each beat, then stall a random count before the next;
  // calm stretches keep ready high throughout
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else if (out_valid && out_ready) begin
      check_result(out_data);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      rx_hold = rx_calm ? 0 : $urandom_range(0, 16);
      out_ready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= (rx_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin
    in_item_t  beat;
    out_item_t typed_res;
    bit        paused;
    paused = 1'b0;
    clear_scan();
    foreach (text_buf[i]) text_buf[i] = 8'h00;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // scripted part
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      beat.char_code    = script_rows[r].ch;
      beat.end_of_input = script_rows[r].eoi;
      typed_res = '{token_kind: script_rows[r].kind, text_char: 8'h00, has_char: 1'b0,
                    token_end: 1'b1, error_code: script_rows[r].err, run_last: 1'b1};
      send_beat(beat, script_rows[r].typed, typed_res);
    end

    // let the scripted results all land before the random streams
    drain();
    useful_beats = 0;

    // random token streams, with one more full drain halfway through
    while (useful_beats < RANDOM_BEATS) begin
      plan_token();
      foreach (plan[i]) send_beat(plan[i], MODEL, '0);
      if (!paused && useful_beats >= RANDOM_BEATS / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d input beats, %0d result beats checked", beats_sent,
             results_seen);
    $display("  %0d tokens closed, %0d error beats (%0d overflows)", tokens_seen,
             errors_seen, overflows);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("%0t: timeout, %0d result beats still expected", $time, pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/stt_pkg.sv
rtl/stt_out_fifo.sv
rtl/stt_scan_ctrl.sv
rtl/source_text_tokenizer.sv
tb/tb.sv
